// ===== rtl/core/life_automaton_torus_core_assert.svh =====
// ---------------------------------------------------------------------------
// Life automaton assertion macros
// Shorthand for clocked implication checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_TORUS_CORE_ASSERT_SVH
`define LIFE_AUTOMATON_TORUS_CORE_ASSERT_SVH

// same-cycle implication
`define LAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lat_pkg.sv =====
// ---------------------------------------------------------------------------
// Life automaton package
// Board sizes, request and state codes, shared row type.
// ---------------------------------------------------------------------------
package lat_pkg;

  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 32;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int CFG_W    = 6;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 40;

  localparam logic [CFG_W-1:0] ROW_CAP = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] COL_CAP = CFG_W'(MAX_COLS);

  typedef logic [MAX_COLS-1:0] row_t;

  typedef enum logic [1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_TOGGLE = 2'd2,
    REQ_STEP   = 2'd3
  } req_t;

  typedef enum logic {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_PRE0,
    S_PRE1,
    S_CALC
  } state_t;

  function automatic logic [CFG_W-1:0] eff_size(logic [CFG_W-1:0] v,
                                                 logic [CFG_W-1:0] cap);
    logic [CFG_W-1:0] r;
    if (v == '0) r = CFG_W'(1);
    else if (v > cap) r = cap;
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/core/lat_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module lat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lat_gen.sv =====
// ---------------------------------------------------------------------------
// Life automaton row update
// Applies B3/S23 to one row from its wrapped upper and lower neighbors.
// ---------------------------------------------------------------------------
module lat_gen (
  input  lat_pkg::row_t              above,
  input  lat_pkg::row_t              cur,
  input  lat_pkg::row_t              below,
  input  logic [lat_pkg::CFG_W-1:0]  cols,
  output lat_pkg::row_t              next_row
);
  import lat_pkg::*;

  logic [COL_W-1:0] last_col;
  row_t             al, ar, cl, cr, bl, br;
  logic [3:0]       cnt [MAX_COLS];

  function automatic row_t wrap_left(row_t x, logic [COL_W-1:0] lc);
    row_t y;
    y = {x[MAX_COLS-2:0], x[lc]};
    return y;
  endfunction

  function automatic row_t wrap_right(row_t x, logic [COL_W-1:0] lc);
    row_t y;
    y     = {1'b0, x[MAX_COLS-1:1]};
    y[lc] = x[0];
    return y;
  endfunction

  assign last_col = COL_W'(cols - CFG_W'(1));

  assign al = wrap_left(above, last_col);
  assign ar = wrap_right(above, last_col);
  assign cl = wrap_left(cur, last_col);
  assign cr = wrap_right(cur, last_col);
  assign bl = wrap_left(below, last_col);
  assign br = wrap_right(below, last_col);

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      cnt[j] = 4'(al[j]) + 4'(above[j]) + 4'(ar[j]) + 4'(cl[j]) + 4'(cr[j])
             + 4'(bl[j]) + 4'(below[j]) + 4'(br[j]);
      if (CFG_W'(j) < cols) begin
        next_row[j] = (cnt[j] == 4'd3) || (cur[j] && (cnt[j] == 4'd2));
      end else begin
        next_row[j] = cur[j];
      end
    end
  end

endmodule

// ===== rtl/core/life_automaton_torus_core.sv =====
// ---------------------------------------------------------------------------
// Toroidal life automaton core
// Cell access and B3/S23 generation step on a board held in RAM.
// ---------------------------------------------------------------------------
// The board sits in a 32 x 32-bit RAM, one word per row, cleared at reset by
// per-row valid bits, so there is no clearing pass. A read, write or toggle
// reads its row from S_IDLE, is applied in S_ACC and returns one beat. A
// generation preloads rows through S_PRE0 and S_PRE1, then returns one beat
// per active row with the change mask; S_CALC fetches one row ahead per cycle
// while the output is free and the current row is written back. Output
// back-pressure stalls the sequence beat by beat.
module life_automaton_torus_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [lat_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lat_pkg::IN_W-1:0]    s_tdata,  // req_type[1:0] row[6:2] col[11:7] value[12]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lat_pkg::OUT_W-1:0]   m_tdata,  // cell_value[0] row_index[5:1] change_mask[37:6]
  output logic                        m_tlast
);
  import lat_pkg::*;

  state_t           state, state_next;
  logic [CFG_W-1:0] rows_in_use, cols_in_use, h_eff, w_eff;
  logic [MAX_ROWS-1:0] valid;

  req_t             in_req;
  logic [ROW_W-1:0] in_row;
  logic [COL_W-1:0] in_col;
  logic             in_val;

  req_t             acc_req;
  logic [ROW_W-1:0] acc_row;
  logic [COL_W-1:0] acc_col;
  logic             acc_val, acc_hit;
  row_t             acc_word;

  logic [ROW_W-1:0] row_cnt;
  logic [CFG_W-1:0] row_plus1, row_plus2;
  logic             last_row;
  row_t             above_row, cur_row, first_row, below_row, gen_row;

  logic             ram_we, ram_re, rd_ok;
  logic [ROW_W-1:0] ram_waddr, ram_raddr;
  row_t             ram_wdata, ram_rdata, rd_word;

  logic             out_free, out_load, out_last_next, calc_fire;
  logic [OUT_W-1:0] out_word;

  assign h_eff = eff_size(rows_in_use, ROW_CAP);
  assign w_eff = eff_size(cols_in_use, COL_CAP);

  assign in_req = req_t'(s_tdata[1:0]);
  assign in_row = s_tdata[6:2];
  assign in_col = s_tdata[11:7];
  assign in_val = s_tdata[12];

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign rd_word   = ram_rdata & {MAX_COLS{rd_ok}};
  assign row_plus1 = CFG_W'(row_cnt) + CFG_W'(1);
  assign row_plus2 = CFG_W'(row_cnt) + CFG_W'(2);
  assign last_row  = (row_plus1 == h_eff);
  assign below_row = (row_plus1 < h_eff) ? rd_word : first_row;

  always_comb begin
    acc_word = rd_word;
    case (acc_req)
      REQ_WRITE:  acc_word[acc_col] = acc_val;
      REQ_TOGGLE: acc_word[acc_col] = ~rd_word[acc_col];
      default:    acc_word = rd_word;
    endcase
  end

  lat_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_board (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lat_gen u_gen (
    .above   (above_row),
    .cur     (cur_row),
    .below   (below_row),
    .cols    (w_eff),
    .next_row(gen_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = acc_word;
    out_load      = 1'b0;
    out_word      = '0;
    out_last_next = 1'b0;
    calc_fire     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ram_re = 1'b1;
          if (in_req == REQ_STEP) begin
            ram_raddr  = ROW_W'(h_eff - CFG_W'(1));
            state_next = S_PRE0;
          end else begin
            ram_raddr  = in_row;
            state_next = S_ACC;
          end
        end
      end
      S_ACC: begin
        if (out_free) begin
          ram_we        = acc_hit && (acc_req inside {REQ_WRITE, REQ_TOGGLE});
          ram_waddr     = acc_row;
          ram_wdata     = acc_word;
          out_load      = 1'b1;
          out_word      = {{(OUT_W-1){1'b0}}, acc_hit & acc_word[acc_col]};
          out_last_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_PRE0: begin
        ram_re     = 1'b1;
        ram_raddr  = '0;
        state_next = S_PRE1;
      end
      S_PRE1: begin
        if (h_eff > CFG_W'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = ROW_W'(1);
        end
        state_next = S_CALC;
      end
      S_CALC: begin
        if (out_free) begin
          calc_fire     = 1'b1;
          ram_we        = 1'b1;
          ram_waddr     = row_cnt;
          ram_wdata     = gen_row;
          out_load      = 1'b1;
          out_word      = {2'b00, cur_row ^ gen_row, row_cnt, 1'b0};
          out_last_next = last_row;
          if (row_plus2 < h_eff) begin
            ram_re    = 1'b1;
            ram_raddr = ROW_W'(row_plus2);
          end
          if (last_row) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid    <= 1'b0;
      valid       <= '0;
      rows_in_use <= ROW_CAP;
      cols_in_use <= COL_CAP;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ROWS: rows_in_use <= cfg_data;
          CFG_COLS: cols_in_use <= cfg_data;
          default:  rows_in_use <= rows_in_use;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_word;
      m_tlast <= out_last_next;
    end
    if (ram_re) begin
      rd_ok <= valid[ram_raddr];
    end
    if (s_tready && s_tvalid) begin
      acc_req <= in_req;
      acc_row <= in_row;
      acc_col <= in_col;
      acc_val <= in_val;
      acc_hit <= (CFG_W'(in_row) < h_eff) && (CFG_W'(in_col) < w_eff);
      row_cnt <= '0;
    end
    if (state == S_PRE0) begin
      above_row <= rd_word;
    end
    if (state == S_PRE1) begin
      cur_row   <= rd_word;
      first_row <= rd_word;
    end
    if (calc_fire) begin
      above_row <= cur_row;
      cur_row   <= below_row;
      row_cnt   <= row_cnt + ROW_W'(1);
    end
  end

  `include "life_automaton_torus_core_assert.svh"

  `LAT_ASSERT_IMP(a_calc_row_range, state == S_CALC, CFG_W'(row_cnt) < h_eff,
    "row counter beyond active rows")
  `LAT_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr,
    "RAM read and write hit the same row")
  `LAT_ASSERT_IMP(a_we_state, ram_we, (state == S_CALC) || (state == S_ACC),
    "RAM write outside an update state")
  `LAT_ASSERT_NXT(a_step_done, calc_fire && last_row, state == S_IDLE,
    "generation did not end after the last row")

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// Toroidal life automaton core testbench
// Drives cell reads, writes, toggles and generation steps through the input
// stream, and register writes between phases over several board shapes.
// A local board model predicts every output beat, and a monitor compares
// each beat field by field while both sides of the stream idle at random.
// ---------------------------------------------------------------------------
module testbench;
  import lat_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    req_t       kind;
    logic [4:0] row;
    logic [4:0] col;
    logic       value;
  } cell_req_t;

  typedef struct packed {
    logic        alive;
    logic [4:0]  row_index;
    logic [31:0] change_mask;
    logic        last;
  } life_beat_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata   = '0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  cell_req_t  pending_reqs[$];
  life_beat_t expected_beats[$];
  cell_req_t  in_flight;
  cell_req_t  next_req;

  logic [31:0]      life_board [MAX_ROWS];
  logic [CFG_W-1:0] rows_reg = CFG_W'(MAX_ROWS);
  logic [CFG_W-1:0] cols_reg = CFG_W'(MAX_COLS);

  int  src_gap      = 0;
  bit  src_calm     = 1'b0;
  int  sink_hold    = 0;
  bit  sink_calm    = 1'b0;
  int  idle_cycles  = 0;
  int  mismatch_count = 0;
  int  reqs_taken   = 0;
  int  steps_taken  = 0;
  int  beats_seen   = 0;
  int  reg_writes   = 0;

  life_automaton_torus_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int active_extent(logic [CFG_W-1:0] v, int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic advance_generation(int h, int w);
    logic [31:0] old_rows [MAX_ROWS];
    logic [31:0] fresh;
    int n;
    old_rows = life_board;
    for (int i = 0; i < h; i++) begin
      fresh = old_rows[i];
      for (int j = 0; j < w; j++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0)
              n += old_rows[(i + h + dr) % h][(j + w + dc) % w];
          end
        end
        if (!old_rows[i][j]) begin
          if (n == 3) fresh[j] = 1'b1;
        end else if (n < 2 || n > 3) begin
          fresh[j] = 1'b0;
        end
      end
      expected_beats.insert(expected_beats.size(),
                            {1'b0, 5'(i), old_rows[i] ^ fresh, 1'(i == h - 1)});
      life_board[i] = fresh;
    end
  endtask

  task automatic predict_request(cell_req_t q);
    int   h;
    int   w;
    logic alive;
    h = active_extent(rows_reg, MAX_ROWS);
    w = active_extent(cols_reg, MAX_COLS);
    reqs_taken++;
    if (q.kind == REQ_STEP) begin
      steps_taken++;
      advance_generation(h, w);
    end else begin
      alive = 1'b0;
      if (int'(q.row) < h && int'(q.col) < w) begin
        case (q.kind)
          REQ_WRITE:  life_board[q.row][q.col] = q.value;
          REQ_TOGGLE: life_board[q.row][q.col] = ~life_board[q.row][q.col];
          default: ;
        endcase
        alive = life_board[q.row][q.col];
      end
      expected_beats.insert(expected_beats.size(), {alive, 5'd0, 32'd0, 1'b1});
    end
  endtask

  task automatic note_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("beat %0d: %s expected 0x%0h, got 0x%0h", beats_seen, what, want, got);
  endtask

  task automatic check_beat();
    life_beat_t got;
    life_beat_t want;
    got = {m_tdata[0], m_tdata[5:1], m_tdata[37:6], m_tlast};
    beats_seen++;
    if (expected_beats.size() == 0) begin
      note_mismatch("unexpected beat, data", 0, longint'(m_tdata));
    end else begin
      want = expected_beats.pop_front();
      if (got.alive !== want.alive) note_mismatch("cell_value", want.alive, got.alive);
      if (got.row_index !== want.row_index)
        note_mismatch("row_index", want.row_index, got.row_index);
      if (got.change_mask !== want.change_mask)
        note_mismatch("change_mask", want.change_mask, got.change_mask);
      if (got.last !== want.last) note_mismatch("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (s_tvalid && s_tready) predict_request(in_flight);
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          s_tvalid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (pending_reqs.size() != 0) begin
          next_req  = pending_reqs.pop_front();
          in_flight <= next_req;
          s_tvalid  <= 1'b1;
          s_tdata   <= {3'b000, next_req.value, next_req.col, next_req.row, next_req.kind};
          src_gap   <= src_calm ? 0 : idle_len();
          if ($urandom_range(0, 39) == 0) src_calm <= !src_calm;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      sink_hold <= 0;
    end else begin
      if (m_tvalid && m_tready) check_beat();
      if (sink_hold > 0) begin
        m_tready  <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        m_tready <= 1'b1;
        if (!sink_calm && $urandom_range(0, 3) == 0) sink_hold <= idle_len();
      end
      if ($urandom_range(0, 199) == 0) sink_calm <= !sink_calm;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", idle_cycles);
        $display("life_automaton_torus_core: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = val;
    else cols_reg = val;
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || s_tvalid || expected_beats.size() != 0);
  endtask

  task automatic queue_req(req_t k, int r, int c, bit v);
    pending_reqs.insert(pending_reqs.size(), {k, 5'(r), 5'(c), v});
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int extremes [8] = '{0, 1, 2, 3, 31, 32, 33, 63};
    if ($urandom_range(0, 2) == 0) return CFG_W'(extremes[$urandom_range(0, 7)]);
    return CFG_W'($urandom_range(1, 32));
  endfunction

  task automatic random_phase(int count);
    int h;
    int w;
    int p;
    int r;
    int c;
    h = active_extent(rows_reg, MAX_ROWS);
    w = active_extent(cols_reg, MAX_COLS);
    for (int k = 0; k < count; k++) begin
      p = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 85) begin
        r = $urandom_range(0, h - 1);
        c = $urandom_range(0, w - 1);
      end else begin
        r = $urandom_range(0, 31);
        c = $urandom_range(0, 31);
      end
      if (p < 45)      queue_req(REQ_WRITE, r, c, $urandom_range(0, 1));
      else if (p < 60) queue_req(REQ_TOGGLE, r, c, $urandom_range(0, 1));
      else if (p < 82) queue_req(REQ_READ, r, c, $urandom_range(0, 1));
      else             queue_req(REQ_STEP, $urandom_range(0, 31), $urandom_range(0, 31),
                                 $urandom_range(0, 1));
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_ROWS; i++) life_board[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full board: corners, toggles, glider across the wrap corner
    queue_req(REQ_WRITE, 0, 0, 1);
    queue_req(REQ_WRITE, 31, 31, 1);
    queue_req(REQ_READ, 31, 31, 0);
    queue_req(REQ_TOGGLE, 0, 31, 0);
    queue_req(REQ_TOGGLE, 0, 31, 1);
    queue_req(REQ_WRITE, 0, 0, 0);
    queue_req(REQ_WRITE, 31, 31, 0);
    queue_req(REQ_WRITE, 31, 1, 1);
    queue_req(REQ_WRITE, 0, 2, 1);
    queue_req(REQ_WRITE, 1, 0, 1);
    queue_req(REQ_WRITE, 1, 1, 1);
    queue_req(REQ_WRITE, 1, 2, 1);
    queue_req(REQ_STEP, 0, 0, 0);
    queue_req(REQ_STEP, 31, 31, 1);
    wait_drained();

    // zero sizes count as one: a lone cell sees itself eight times
    write_register(CFG_ROWS, 6'd0);
    write_register(CFG_COLS, 6'd0);
    queue_req(REQ_WRITE, 0, 0, 1);
    queue_req(REQ_STEP, 0, 0, 0);
    queue_req(REQ_READ, 0, 0, 0);
    queue_req(REQ_WRITE, 3, 7, 1);
    queue_req(REQ_TOGGLE, 0, 9, 0);
    queue_req(REQ_READ, 3, 7, 0);
    wait_drained();

    // two rows, oversized columns saturate
    write_register(CFG_ROWS, 6'd2);
    write_register(CFG_COLS, 6'd63);
    queue_req(REQ_WRITE, 1, 5, 1);
    queue_req(REQ_WRITE, 1, 6, 1);
    queue_req(REQ_STEP, 0, 0, 0);
    queue_req(REQ_TOGGLE, 2, 5, 1);
    wait_drained();

    write_register(CFG_ROWS, 6'd33);
    write_register(CFG_COLS, 6'd1);
    queue_req(REQ_WRITE, 10, 0, 1);
    queue_req(REQ_STEP, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      write_register(CFG_ROWS, pick_size());
      write_register(CFG_COLS, pick_size());
      random_phase(50);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_beats.size() != 0) begin
      mismatch_count += expected_beats.size();
      $display("%0d expected beats never arrived", expected_beats.size());
    end
    $display("covered %0d requests with %0d generation steps, %0d beats checked",
             reqs_taken, steps_taken, beats_seen);
    $display("board shapes changed by %0d register writes, %0d mismatches",
             reg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("life_automaton_torus_core: match");
    end else begin
      $display("life_automaton_torus_core: mismatch");
    end
    $finish;
  end

endmodule
